[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the biquad checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, held off while arst_n is low.
`define DCBQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen.
`define DCBQ_NEVER(lbl, cond, msg) \
	`DCBQ_ASSERT(lbl, !(cond), msg)

`endif

[hdl/dcbq_pkg.sv]
// ---------------------------------------------------------------------------
// dcbq_pkg
// Shared constants and types of the dual-channel biquad low-pass core.
// ---------------------------------------------------------------------------
package dcbq_pkg;

	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int COEF_FRAC_BITS_DEF = 30;

	localparam int DELAY_BITS  = 48;   // delay terms and accumulator
	localparam int COEF_A_BITS = 31;   // a0, unsigned
	localparam int COEF_B_BITS = 32;   // b1, b2, signed
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 32;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_A0 = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 2'd2;

	// per-step enables from the sequencer to the lanes
	typedef struct packed {
		logic load;   // item accepted: form x*a0
		logic acc;    // p + d1
		logic mul;    // feedback partial products, output rounding
		logic fb;     // feedback sums
		logic upd;    // delay write-back
	} ctl_t;

endpackage

[hdl/dcbq_lane.sv]
// ---------------------------------------------------------------------------
// dcbq_lane
// One biquad channel: TDF-II low-pass step with 48-bit saturating delays.
// ---------------------------------------------------------------------------
module dcbq_lane #(
	parameter int SAMPLE_WIDTH   = dcbq_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = dcbq_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  dcbq_pkg::ctl_t                            ctl,
	input  logic signed [SAMPLE_WIDTH-1:0]            sample,
	input  logic                                      restart,
	input  logic        [dcbq_pkg::COEF_A_BITS-1:0]   coef_a0,
	input  logic signed [dcbq_pkg::COEF_B_BITS-1:0]   coef_b1,
	input  logic signed [dcbq_pkg::COEF_B_BITS-1:0]   coef_b2,
	output logic signed [SAMPLE_WIDTH-1:0]            filtered
);

	localparam int DW  = dcbq_pkg::DELAY_BITS;
	localparam int CBW = dcbq_pkg::COEF_B_BITS;
	localparam int LOW = 32;                 // split point of acc
	localparam int HIW = DW - LOW;           // upper acc slice width
	localparam int PLW = CBW + LOW + 1;      // b * acc[31:0]
	localparam int PHW = CBW + HIW;          // b * acc[47:32]
	localparam int WW  = 64;                 // working width for sums
	localparam int PRW = DW + CBW;           // full feedback product

	localparam logic signed [WW-1:0]  DMAX_W = (WW'(1) <<< (DW-1)) - WW'(1);
	localparam logic signed [WW-1:0]  DMIN_W = -(WW'(1) <<< (DW-1));
	localparam logic signed [PRW-1:0] DMAX_P = (PRW'(1) <<< (DW-1)) - PRW'(1);
	localparam logic signed [PRW-1:0] DMIN_P = -(PRW'(1) <<< (DW-1));
	localparam logic signed [WW-1:0]  RND_W  = WW'(1) <<< (COEF_FRAC_BITS-1);
	localparam logic signed [PRW-1:0] RND_P  = PRW'(1) <<< (COEF_FRAC_BITS-1);
	localparam logic signed [WW-1:0]  SMAX_W = (WW'(1) <<< (SAMPLE_WIDTH-1)) - WW'(1);
	localparam logic signed [WW-1:0]  SMIN_W = -(WW'(1) <<< (SAMPLE_WIDTH-1));

	function automatic logic signed [DW-1:0] sat_w(input logic signed [WW-1:0] v);
		logic signed [WW-1:0] r;
		if (v > DMAX_W) r = DMAX_W;
		else if (v < DMIN_W) r = DMIN_W;
		else r = v;
		return r[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] sat_p(input logic signed [PRW-1:0] v);
		logic signed [PRW-1:0] r;
		if (v > DMAX_P) r = DMAX_P;
		else if (v < DMIN_P) r = DMIN_P;
		else r = v;
		return r[DW-1:0];
	endfunction

	logic signed [DW-1:0]  p_s1;
	logic                  rst_s1;
	logic signed [DW-1:0]  acc_s2;
	logic signed [PLW-1:0] pl1_s3, pl2_s3;
	logic signed [PHW-1:0] ph1_s3, ph2_s3;
	logic                  neg1_s3, neg2_s3;
	logic signed [DW-1:0]  fb1_s4, fb2_s4;
	logic signed [DW-1:0]  d1_q, d2_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q;

	logic signed [WW-1:0]  px;
	logic signed [WW-1:0]  acc_sum;
	logic signed [WW-1:0]  ro;
	logic signed [PRW-1:0] sum1, sum2;
	logic signed [WW-1:0]  d1_sum, d2_sum;
	logic signed [LOW:0]   acc_lo;
	logic signed [HIW-1:0] acc_hi;

	assign px      = $signed(sample) * $signed({1'b0, coef_a0});
	assign acc_sum = WW'(p_s1) + (rst_s1 ? WW'(0) : WW'(d1_q));
	assign acc_lo  = $signed({1'b0, acc_s2[LOW-1:0]});
	assign acc_hi  = acc_s2[DW-1:LOW];

	// round half away from zero: add half, minus one when negative, then shift
	assign ro = (WW'(acc_s2) + RND_W - $signed({{(WW-1){1'b0}}, acc_s2[DW-1]}))
		>>> COEF_FRAC_BITS;

	assign sum1 = (PRW'(pl1_s3) + (PRW'(ph1_s3) <<< LOW) + RND_P
		- $signed({{(PRW-1){1'b0}}, neg1_s3})) >>> COEF_FRAC_BITS;
	assign sum2 = (PRW'(pl2_s3) + (PRW'(ph2_s3) <<< LOW) + RND_P
		- $signed({{(PRW-1){1'b0}}, neg2_s3})) >>> COEF_FRAC_BITS;

	assign d1_sum = (WW'(p_s1) <<< 1) + (rst_s1 ? WW'(0) : WW'(d2_q)) - WW'(fb1_s4);
	assign d2_sum = WW'(p_s1) - WW'(fb2_s4);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			p_s1 <= sat_w(px);
		end
		if (ctl.acc) begin
			acc_s2 <= sat_w(acc_sum);
		end
		if (ctl.mul) begin
			pl1_s3  <= PLW'(coef_b1 * acc_lo);
			ph1_s3  <= PHW'(coef_b1 * acc_hi);
			pl2_s3  <= PLW'(coef_b2 * acc_lo);
			ph2_s3  <= PHW'(coef_b2 * acc_hi);
			neg1_s3 <= (coef_b1[CBW-1] ^ acc_s2[DW-1]) && (coef_b1 != '0) && (acc_s2 != '0);
			neg2_s3 <= (coef_b2[CBW-1] ^ acc_s2[DW-1]) && (coef_b2 != '0) && (acc_s2 != '0);
			if (ro > SMAX_W) out_q <= SMAX_W[SAMPLE_WIDTH-1:0];
			else if (ro < SMIN_W) out_q <= SMIN_W[SAMPLE_WIDTH-1:0];
			else out_q <= ro[SAMPLE_WIDTH-1:0];
		end
		if (ctl.fb) begin
			fb1_s4 <= sat_p(sum1);
			fb2_s4 <= sat_p(sum2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_s1 <= 1'b0;
			d1_q   <= '0;
			d2_q   <= '0;
		end else begin
			if (ctl.load) begin
				rst_s1 <= restart;
			end
			if (ctl.upd) begin
				d1_q <= sat_w(d1_sum);
				d2_q <= sat_w(d2_sum);
			end
		end
	end

	assign filtered = out_q;

endmodule

[hdl/dual_channel_biquad_lowpass_core.sv]
// ---------------------------------------------------------------------------
// dual_channel_biquad_lowpass_core
// Second-order TDF-II low-pass on the x and y parts of a vector sample.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    tdata: sample_x, sample_y; tuser: restart
//  m_        out  m_tvalid/m_tready    tdata: filtered_x, filtered_y
//  cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data (a0, b1, b2)
//
//  An item steps through x*a0, p+d1, feedback products, feedback sums,
//  with the delay write-back on the edge that accepts the next item.
//  The delay recursion (d1 feeds acc feeds d1) keeps the next item out
//  until that write-back. m_tvalid rises on the write-back edge; a stalled m_
//  holds the core in its write-back step, so the next item waits but
//  nothing is dropped.
//  arst_n clears the delays, the coefficients and the output valid.
//  cfg_ready is always high; writes are meant for idle periods.
//
module dual_channel_biquad_lowpass_core #(
	parameter int SAMPLE_WIDTH   = dcbq_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = dcbq_pkg::COEF_FRAC_BITS_DEF,
	parameter int TDATA_WIDTH    = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [TDATA_WIDTH-1:0]                 s_tdata,   // sample_x, sample_y, pad
	input  logic                                   s_tuser,   // restart
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [TDATA_WIDTH-1:0]                 m_tdata,   // filtered_x, filtered_y, pad
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [dcbq_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [dcbq_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ACC  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_FB   = 5'b01000,
		ST_UPD  = 5'b10000
	} state_t;

	state_t state_q, state_nxt;

	logic        [dcbq_pkg::COEF_A_BITS-1:0] coef_a0_q;
	logic signed [dcbq_pkg::COEF_B_BITS-1:0] coef_b1_q;
	logic signed [dcbq_pkg::COEF_B_BITS-1:0] coef_b2_q;

	dcbq_pkg::ctl_t ctl;
	logic in_acc;
	logic upd_go;
	logic out_valid_q;
	logic [2*SAMPLE_WIDTH-1:0] out_data_q;
	logic signed [SAMPLE_WIDTH-1:0] fx, fy;

	// ---- configuration ----------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a0_q <= '0;
			coef_b1_q <= '0;
			coef_b2_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dcbq_pkg::REG_A0: coef_a0_q <= cfg_data[dcbq_pkg::COEF_A_BITS-1:0];
				dcbq_pkg::REG_B1: coef_b1_q <= cfg_data;
				dcbq_pkg::REG_B2: coef_b2_q <= cfg_data;
				default: ;  // unknown index: ignored
			endcase
		end
	end

	// ---- sequencer --------------------------------------------------------
	// write-back only when the output register is free this cycle
	assign upd_go   = (state_q == ST_UPD) && (!out_valid_q || m_tready);
	assign s_tready = (state_q == ST_IDLE) || upd_go;
	assign in_acc   = s_tvalid && s_tready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_nxt = ST_ACC;
			ST_ACC:  state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_FB;
			ST_FB:   state_nxt = ST_UPD;
			ST_UPD: begin
				if (upd_go) state_nxt = in_acc ? ST_ACC : ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign ctl.load = in_acc;
	assign ctl.acc  = (state_q == ST_ACC);
	assign ctl.mul  = (state_q == ST_MUL);
	assign ctl.fb   = (state_q == ST_FB);
	assign ctl.upd  = upd_go;

	// ---- lanes: x and y share coefficients and control ---------------------
	dcbq_lane #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_lane_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sample   (s_tdata[SAMPLE_WIDTH-1:0]),
		.restart  (s_tuser),
		.coef_a0  (coef_a0_q),
		.coef_b1  (coef_b1_q),
		.coef_b2  (coef_b2_q),
		.filtered (fx)
	);

	dcbq_lane #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_lane_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sample   (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
		.restart  (s_tuser),
		.coef_a0  (coef_a0_q),
		.coef_b1  (coef_b1_q),
		.coef_b2  (coef_b2_q),
		.filtered (fy)
	);

	// ---- merge: both lane results into one output item ---------------------
	always_ff @(posedge clk) begin
		if (upd_go) begin
			out_data_q <= {fy, fx};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_WIDTH'(out_data_q);

endmodule

[hdl/dcbq_checker.sv]
// ---------------------------------------------------------------------------
// dcbq_checker
// Port-level assertions for the dual-channel biquad core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dcbq_checker #(
	parameter int TDATA_WIDTH = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [TDATA_WIDTH-1:0] m_tdata
);

	// stalled result holds
	`DCBQ_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output changed while stalled")

	// one item in flight: no accept right after an accept
	`DCBQ_NEVER(a_one_in_flight, $past(s_tvalid && s_tready) && s_tready && $past(arst_n), "back-to-back accept")

	// every accepted item is expected to raise m_tvalid after the ACC, MUL, FB and UPD steps
	`DCBQ_ASSERT(a_result_due, s_tvalid && s_tready |-> ##5 m_tvalid, "result missing after item")

	// a taken result is not shown again unless a new one is written back
	`DCBQ_ASSERT(a_no_dup, m_tvalid && m_tready && !s_tready |=> !m_tvalid, "result repeated")

endmodule

bind dual_channel_biquad_lowpass_core dcbq_checker #(
	.TDATA_WIDTH (TDATA_WIDTH)
) u_dcbq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[sim/tb_dual_channel_biquad_lowpass_core.sv]
// ---------------------------------------------------------------------------
// tb_dual_channel_biquad_lowpass_core
// Self-checking bench for the dual-channel TDF-II biquad low-pass core.
// A bit-true software filter tracks the coefficients and the four delay
// terms, predicts each filtered vector when an input item is accepted, and
// compares it field by field with what leaves the master side. Directed
// items cover reset coefficients, the ignored register index, saturation of
// the output and of the delays, and restart; random phases then run stable
// and runaway coefficient sets with random stalls on both stream sides.
// ---------------------------------------------------------------------------
module tb_dual_channel_biquad_lowpass_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW   = dcbq_pkg::SAMPLE_WIDTH_DEF;
	localparam int FRAC = dcbq_pkg::COEF_FRAC_BITS_DEF;
	localparam int TDW  = ((2 * SW + 7) / 8) * 8;
	localparam int IDXW = dcbq_pkg::CFG_IDX_BITS;
	localparam int CDW  = dcbq_pkg::CFG_DATA_BITS;
	localparam int DBW  = dcbq_pkg::DELAY_BITS;

	localparam longint ONE   = longint'(1) << FRAC;        // 1.0 in Q2.30
	localparam longint B_MIN = -(longint'(1) << 31);
	localparam longint B_MAX = (longint'(1) << 31) - 1;

	// register index with nothing behind it; writes must be dropped
	localparam logic [IDXW-1:0] REG_NONE = 2'd3;

	localparam logic signed [SW-1:0] SMP_MAX = SW'((1 <<< (SW - 1)) - 1);
	localparam logic signed [SW-1:0] SMP_MIN = SW'(-(1 <<< (SW - 1)));

	// roughly 0.1 fs cutoff, Q near 0.707, unity DC gain
	localparam longint LP_B1 = -64'sd1226970000;
	localparam longint LP_B2 = 64'sd443236000;
	localparam longint LP_A0 = (ONE + LP_B1 + LP_B2) / 4;

	localparam int IDLE_PCT      = 12;
	localparam int STALL_LIMIT   = 2000;   // cycles with no handshake at all
	localparam int SETTLE_CYCLES = 12;     // core write-back tail before a cfg write
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 200;
	localparam int MAX_REPORTED  = 10;

	typedef struct packed {
		logic [SW-1:0] filtered_y;
		logic [SW-1:0] filtered_x;
	} filtered_pair_t;

	// Software copy of the filter: coefficients, delays and the results
	// still owed by the core, oldest first.
	class vector_lowpass_model;
		longint gain_a0;
		longint fb_b1;
		longint fb_b2;
		longint near_dly[2];   // d1 per lane, x then y
		longint far_dly[2];    // d2 per lane
		filtered_pair_t pending_outputs[$];
		int fault_count;

		function new();
			gain_a0 = 0;
			fb_b1 = 0;
			fb_b2 = 0;
			near_dly = '{0, 0};
			far_dly = '{0, 0};
			fault_count = 0;
		endfunction

		function void set_coef(logic [IDXW-1:0] idx, logic [CDW-1:0] data);
			case (idx)
				dcbq_pkg::REG_A0: gain_a0 = longint'(data[dcbq_pkg::COEF_A_BITS-1:0]);
				dcbq_pkg::REG_B1: fb_b1 = longint'($signed(data));
				dcbq_pkg::REG_B2: fb_b2 = longint'($signed(data));
				default: ;
			endcase
		endfunction

		function longint clamp(longint v, int bits);
			longint hi;
			longint lo;
			hi = (longint'(1) << (bits - 1)) - 1;
			lo = -hi - 1;
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		// coef*acc / 2^F, rounded half away from zero on the magnitude,
		// then clamped to the 48-bit delay range
		function longint scaled_product(longint coef, longint acc);
			bit neg;
			bit [63:0] ua;
			bit [63:0] ub;
			bit [127:0] mag;
			bit [127:0] cap;
			neg = (coef < 0) != (acc < 0);
			ua = coef < 0 ? -coef : coef;
			ub = acc < 0 ? -acc : acc;
			mag = ({64'd0, ua} * {64'd0, ub} + (128'd1 << (FRAC - 1))) >> FRAC;
			cap = neg ? (128'd1 << (DBW - 1)) : (128'd1 << (DBW - 1)) - 1;
			if (mag > cap)
				mag = cap;
			return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
		endfunction

		function logic [SW-1:0] to_sample(longint acc);
			bit [63:0] m;
			longint r;
			m = acc < 0 ? -acc : acc;
			m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
			r = acc < 0 ? -longint'(m) : longint'(m);
			r = clamp(r, SW);
			return r[SW-1:0];
		endfunction

		function logic [SW-1:0] run_lane(int ch, logic signed [SW-1:0] level);
			longint p;
			longint acc;
			longint fb1;
			longint fb2;
			p = clamp(longint'(level) * gain_a0, DBW);
			acc = clamp(p + near_dly[ch], DBW);
			// feedback works on the full 48-bit acc, not the rounded output
			fb1 = scaled_product(fb_b1, acc);
			fb2 = scaled_product(fb_b2, acc);
			near_dly[ch] = clamp(2 * p + far_dly[ch] - fb1, DBW);
			far_dly[ch] = clamp(p - fb2, DBW);
			return to_sample(acc);
		endfunction

		function void note_sample(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
				logic restart);
			filtered_pair_t res;
			if (restart) begin
				near_dly = '{0, 0};
				far_dly = '{0, 0};
			end
			res.filtered_x = run_lane(0, x);
			res.filtered_y = run_lane(1, y);
			pending_outputs.push_back(res);
		endfunction

		function void flag(string msg);
			fault_count++;
			if (fault_count <= MAX_REPORTED)
				$display("%0t mismatch: %s", $time, msg);
		endfunction

		function void check_filtered(logic [SW-1:0] fx, logic [SW-1:0] fy);
			filtered_pair_t want;
			if (pending_outputs.size() == 0) begin
				flag($sformatf("result x=%0d y=%0d with nothing pending",
					$signed(fx), $signed(fy)));
				return;
			end
			want = pending_outputs.pop_front();
			if (fx !== want.filtered_x)
				flag($sformatf("filtered_x expected %0d, got %0d",
					$signed(want.filtered_x), $signed(fx)));
			if (fy !== want.filtered_y)
				flag($sformatf("filtered_y expected %0d, got %0d",
					$signed(want.filtered_y), $signed(fy)));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [TDW-1:0] s_tdata;     // sample_x, sample_y
	logic s_tuser;               // restart
	logic m_tvalid;
	logic m_tready;
	logic [TDW-1:0] m_tdata;     // filtered_x, filtered_y
	logic cfg_valid;
	logic cfg_ready;
	logic [IDXW-1:0] cfg_index;
	logic [CDW-1:0] cfg_data;

	bit steady;                  // no idling on either side while set
	int quiet_cycles = 0;
	vector_lowpass_model sb;

	dual_channel_biquad_lowpass_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Receiver: random back-pressure, held off during reset.
	always @(negedge clk) begin
		m_tready <= arst_n && (steady || $urandom_range(99, 0) >= IDLE_PCT);
	end

	// Results are taken at the edge that completes the handshake.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_filtered(m_tdata[SW-1:0], m_tdata[2*SW-1:SW]);
	end

	// Watchdog: any handshake restarts the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// One item on the slave side; valid stays high into the next call so
	// back-to-back items need no gap.
	task automatic send_sample(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
			logic restart);
		@(negedge clk);
		while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= TDW'({y, x});
		s_tuser <= restart;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(x, y, restart);
	endtask

	// Stop sending and hold until the core has handed back every result,
	// plus the write-back tail.
	task automatic wait_for_outputs();
		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [IDXW-1:0] idx, logic [CDW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_coef(idx, data);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic program_filter(longint a0, longint b1, longint b2);
		write_register(dcbq_pkg::REG_A0, a0[CDW-1:0]);
		write_register(dcbq_pkg::REG_B1, b1[CDW-1:0]);
		write_register(dcbq_pkg::REG_B2, b2[CDW-1:0]);
	endtask

	// Mostly full-range noise, some low-level signal, some rail values.
	function automatic logic signed [SW-1:0] pick_level();
		int mode;
		mode = $urandom_range(9, 0);
		if (mode < 6)
			return SW'($urandom());
		if (mode < 8)
			return SW'(int'($urandom_range(600, 0)) - 300);
		case ($urandom_range(3, 0))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	initial begin
		longint a0;
		longint b1;
		longint b2;
		int b2m;
		int b1m;
		int lim;
		logic rst;

		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// coefficients straight out of reset: every output is zero
		send_sample(SMP_MAX, SMP_MIN, 1'b0);
		send_sample(SW'(-1), SW'(1), 1'b1);
		wait_for_outputs();

		// unmapped index must leave the filter untouched
		write_register(REG_NONE, '1);
		send_sample(SW'(1000), SW'(-1000), 1'b0);
		wait_for_outputs();

		// a0 = 1.0 (top data bit is not part of a0), no feedback:
		// a 1-2-1 FIR that drives the outputs into the rails
		write_register(dcbq_pkg::REG_A0, 32'hC000_0000);
		write_register(dcbq_pkg::REG_B1, '0);
		write_register(dcbq_pkg::REG_B2, '0);
		send_sample(SMP_MAX, SMP_MIN, 1'b1);
		send_sample(SMP_MAX, SMP_MIN, 1'b0);
		send_sample(SMP_MIN, SMP_MAX, 1'b0);
		send_sample('0, '0, 1'b0);
		send_sample('0, '0, 1'b0);
		send_sample(SW'(1), SW'(-1), 1'b0);
		send_sample(SW'(-1), SW'(1), 1'b0);
		send_sample(SMP_MAX, SMP_MIN, 1'b1);
		wait_for_outputs();

		// ordinary low-pass: step response, then restart mid-stream
		program_filter(LP_A0, LP_B1, LP_B2);
		repeat (4) send_sample(SMP_MAX, SMP_MIN, 1'b0);
		send_sample(SMP_MIN, SMP_MAX, 1'b1);
		send_sample(SW'(-1), SW'(1), 1'b0);
		send_sample(SW'(1), SW'(-1), 1'b0);
		send_sample('0, '0, 1'b0);
		wait_for_outputs();

		// unstable extremes: delays run into the 48-bit clamp
		program_filter(ONE, B_MIN, ONE);
		send_sample(SMP_MAX, SMP_MIN, 1'b0);
		send_sample(SMP_MIN, SMP_MAX, 1'b0);
		send_sample(SMP_MAX, SMP_MIN, 1'b0);
		wait_for_outputs();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				1: begin
					// a0 from 0 to 1.0, any b1, b2 from -1.0 to 1.0
					a0 = longint'($urandom_range(32'(ONE), 0));
					b1 = longint'($signed($urandom()));
					b2 = longint'($urandom_range(32'(2 * ONE), 0)) - ONE;
				end
				3: begin
					if (ph == 3) begin
						a0 = ONE;
						b1 = B_MIN;
						b2 = ONE;
					end else begin
						a0 = longint'($urandom_range(32'(ONE), 0));
						b1 = B_MAX;
						b2 = -ONE;
					end
				end
				default: begin
					// poles inside the stability triangle, unity DC gain
					b2m = int'($urandom_range(1850, 0)) - 900;
					lim = (1000 + b2m) * 95 / 100;
					b1m = int'($urandom_range(2 * lim, 0)) - lim;
					b2 = longint'(b2m) * ONE / 1000;
					b1 = longint'(b1m) * ONE / 1000;
					a0 = (ONE + b1 + b2) / 4;
				end
			endcase
			program_filter(a0, b1, b2);
			steady = (ph == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				rst = (n == 0) ? 1'($urandom_range(1, 0)) : ($urandom_range(99, 0) < 3);
				send_sample(pick_level(), pick_level(), rst);
				// sender holds mid-phase until the core has caught up
				if (ph == 6 && n == PHASE_ITEMS / 2)
					wait_for_outputs();
			end
			wait_for_outputs();
		end
		steady = 1'b0;

		repeat (20) @(posedge clk);
		if (sb.fault_count == 0 && sb.pending_outputs.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
